[rtl/double_ended_queue_assert.svh]
// assertion macros used by the queue control module
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// clocked check, switched off while reset is low
`define DEQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check that also holds through reset
`define DEQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DEQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define DEQ_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[rtl/deq_pkg.sv]
package deq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int VALUE_W   = 32;

    localparam logic signed [VALUE_W-1:0] INT_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    typedef enum logic [2:0] {
        ACT_PUSH_HEAD = 3'd0,
        ACT_PUSH_TAIL = 3'd1,
        ACT_POP_HEAD  = 3'd2,
        ACT_POP_TAIL  = 3'd3,
        ACT_QUERY     = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_POP_EMPTY = 2'd1,
        ST_PUSH_FULL = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_FETCH
    } t_state;

    typedef struct packed {
        logic signed [VALUE_W-1:0] popped;
        logic [1:0]                status;
        logic signed [VALUE_W-1:0] head;
        logic signed [VALUE_W-1:0] tail;
        logic                      empty;
    } t_deq_result;

endpackage

[rtl/deq_ram.sv]
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/deq_ctrl.sv]
module deq_ctrl #(
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic [2:0]                             i_action,
    input  logic signed [deq_pkg::VALUE_W-1:0]     i_push_value,
    output logic                                   o_busy,
    output logic                                   o_valid,
    output deq_pkg::t_deq_result                   o_result,
    output logic                                   o_we,
    output logic [$clog2(DEPTH)-1:0]               o_waddr,
    output logic [deq_pkg::VALUE_W-1:0]            o_wdata,
    output logic                                   o_re,
    output logic [$clog2(DEPTH)-1:0]               o_raddr,
    input  logic [deq_pkg::VALUE_W-1:0]            i_rdata
);

    import deq_pkg::*;
    `include "double_ended_queue_assert.svh"

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_state                r_state, n_state;
    logic [IW-1:0]         r_front, n_front;
    logic [IW-1:0]         r_back, n_back;
    logic [CW-1:0]         r_count, n_count;
    logic signed [VALUE_W-1:0] r_head, n_head;
    logic signed [VALUE_W-1:0] r_tail, n_tail;
    logic                  r_pop_head, n_pop_head;
    logic                  r_valid, n_valid;
    t_deq_result           r_res, n_res;

    logic          accept;
    logic          ring_empty;
    logic          is_full;
    logic [IW-1:0] front_inc, front_dec, back_inc, back_dec;

    function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] idx);
        return (idx == IW'(DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    function automatic logic [IW-1:0] wrap_dec(input logic [IW-1:0] idx);
        return (idx == '0) ? IW'(DEPTH - 1) : idx - 1'b1;
    endfunction

    assign o_busy     = (r_state == S_FETCH);
    assign accept     = i_start && !o_busy;
    assign ring_empty = (r_count == '0);
    assign is_full    = (r_count == CW'(DEPTH));
    assign front_inc  = wrap_inc(r_front);
    assign front_dec  = wrap_dec(r_front);
    assign back_inc   = wrap_inc(r_back);
    assign back_dec   = wrap_dec(r_back);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_front <= '0;
            r_back  <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_back  <= n_back;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    // cached end values and the result register carry no reset
    always_ff @(posedge i_clk) begin
        r_head     <= n_head;
        r_tail     <= n_tail;
        r_pop_head <= n_pop_head;
        r_res      <= n_res;
    end

    always_comb begin
        n_state    = r_state;
        n_front    = r_front;
        n_back     = r_back;
        n_count    = r_count;
        n_head     = r_head;
        n_tail     = r_tail;
        n_pop_head = r_pop_head;
        n_valid    = 1'b0;
        n_res      = r_res;
        o_we       = 1'b0;
        o_waddr    = r_back;
        o_wdata    = i_push_value;
        o_re       = 1'b0;
        o_raddr    = front_inc;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_valid      = 1'b1;
                    n_res.popped = INT_MIN;
                    n_res.status = ST_OK;
                    n_res.head   = ring_empty ? INT_MIN : r_head;
                    n_res.tail   = ring_empty ? INT_MIN : r_tail;
                    n_res.empty  = ring_empty;
                    case (i_action)
                        ACT_PUSH_HEAD: begin
                            if (is_full) begin
                                n_res.status = ST_PUSH_FULL;
                            end else begin
                                o_we        = 1'b1;
                                o_waddr     = front_dec;
                                n_front     = front_dec;
                                n_count     = r_count + 1'b1;
                                n_head      = i_push_value;
                                n_res.head  = i_push_value;
                                n_res.empty = 1'b0;
                                if (ring_empty) begin
                                    n_tail     = i_push_value;
                                    n_res.tail = i_push_value;
                                end
                            end
                        end
                        ACT_PUSH_TAIL: begin
                            if (is_full) begin
                                n_res.status = ST_PUSH_FULL;
                            end else begin
                                o_we        = 1'b1;
                                o_waddr     = r_back;
                                n_back      = back_inc;
                                n_count     = r_count + 1'b1;
                                n_tail      = i_push_value;
                                n_res.tail  = i_push_value;
                                n_res.empty = 1'b0;
                                if (ring_empty) begin
                                    n_head     = i_push_value;
                                    n_res.head = i_push_value;
                                end
                            end
                        end
                        ACT_POP_HEAD: begin
                            if (ring_empty) begin
                                n_res.status = ST_POP_EMPTY;
                            end else begin
                                n_res.popped = r_head;
                                n_front      = front_inc;
                                n_count      = r_count - 1'b1;
                                if (r_count == CW'(1)) begin
                                    n_res.head  = INT_MIN;
                                    n_res.tail  = INT_MIN;
                                    n_res.empty = 1'b1;
                                end else begin
                                    // new front entry comes back from the ram next cycle
                                    o_re       = 1'b1;
                                    o_raddr    = front_inc;
                                    n_pop_head = 1'b1;
                                    n_valid    = 1'b0;
                                    n_state    = S_FETCH;
                                end
                            end
                        end
                        ACT_POP_TAIL: begin
                            if (ring_empty) begin
                                n_res.status = ST_POP_EMPTY;
                            end else begin
                                n_res.popped = r_tail;
                                n_back       = back_dec;
                                n_count      = r_count - 1'b1;
                                if (r_count == CW'(1)) begin
                                    n_res.head  = INT_MIN;
                                    n_res.tail  = INT_MIN;
                                    n_res.empty = 1'b1;
                                end else begin
                                    // back_dec now points just past the back entry
                                    o_re       = 1'b1;
                                    o_raddr    = wrap_dec(back_dec);
                                    n_pop_head = 1'b0;
                                    n_valid    = 1'b0;
                                    n_state    = S_FETCH;
                                end
                            end
                        end
                        ACT_QUERY: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FETCH: begin
                n_valid = 1'b1;
                n_state = S_IDLE;
                if (r_pop_head) begin
                    n_head     = $signed(i_rdata);
                    n_res.head = $signed(i_rdata);
                end else begin
                    n_tail     = $signed(i_rdata);
                    n_res.tail = $signed(i_rdata);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_valid  = r_valid;
    assign o_result = r_res;

    `DEQ_ASSERT(a_count_range, i_clk, i_rst_n, r_count <= CW'(DEPTH), "entry count beyond depth")
    `DEQ_ASSERT(a_fetch_one_cycle, i_clk, i_rst_n, (r_state == S_FETCH) |=> (r_state == S_IDLE), "fetch state held")
    `DEQ_ASSERT(a_fetch_gives_result, i_clk, i_rst_n, (r_state == S_FETCH) |=> r_valid, "fetch without result")
    `DEQ_ASSERT(a_empty_matches, i_clk, i_rst_n, r_valid |-> (r_res.empty == (r_count == '0)), "empty flag disagrees with count")
    `DEQ_ASSERT(a_no_write_in_fetch, i_clk, i_rst_n, (r_state == S_FETCH) |-> !o_we, "ram written during fetch")

endmodule

[rtl/double_ended_queue.sv]
// channel   direction  transfer condition     ports
// command   in         start && !busy         i_action, i_push_value
// result    out        o_valid (one cycle)    o_popped_value, o_status, o_head_value,
//                                             o_tail_value, o_is_empty_flag
//
// pushes, queries, failed ops and a pop that leaves the queue empty: result in the cycle
// after the command, busy stays low, so one command per cycle
// any other pop: busy high for one cycle while the new end entry is read back
// from the entry ram (one read port, registered read data)
// synchronous active-low reset empties the queue; ram contents are not cleared
// the receiver cannot stall: each result shows for exactly one cycle
module double_ended_queue #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [2:0]                         i_action,
    input  logic signed [deq_pkg::VALUE_W-1:0] i_push_value,
    output logic                               o_valid,
    output logic signed [deq_pkg::VALUE_W-1:0] o_popped_value,
    output logic [1:0]                         o_status,
    output logic signed [deq_pkg::VALUE_W-1:0] o_head_value,
    output logic signed [deq_pkg::VALUE_W-1:0] o_tail_value,
    output logic                               o_is_empty_flag
);

    import deq_pkg::*;

    localparam int IW = $clog2(DEPTH);

    t_deq_result        result;
    logic               ram_we;
    logic [IW-1:0]      ram_waddr;
    logic [VALUE_W-1:0] ram_wdata;
    logic               ram_re;
    logic [IW-1:0]      ram_raddr;
    logic [VALUE_W-1:0] ram_rdata;

    deq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_action     (i_action),
        .i_push_value (i_push_value),
        .o_busy       (busy),
        .o_valid      (o_valid),
        .o_result     (result),
        .o_we         (ram_we),
        .o_waddr      (ram_waddr),
        .o_wdata      (ram_wdata),
        .o_re         (ram_re),
        .o_raddr      (ram_raddr),
        .i_rdata      (ram_rdata)
    );

    deq_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_popped_value  = result.popped;
    assign o_status        = result.status;
    assign o_head_value    = result.head;
    assign o_tail_value    = result.tail;
    assign o_is_empty_flag = result.empty;

endmodule
